// ===== rtl/ibmw_pkg.sv =====
// Package for the inode block map walker.
// Item types, status codes and controller states; no dependencies.
package ibmw_pkg;

   localparam int LB_WIDTH  = 16;
   localparam int PB_WIDTH  = 8;
   localparam int CSR_WIDTH = 9;

   localparam logic [1:0] ST_MAPPED   = 2'd0;
   localparam logic [1:0] ST_UNMAPPED = 2'd1;
   localparam logic [1:0] ST_NOSPACE  = 2'd2;
   localparam logic [1:0] ST_RANGE    = 2'd3;

   localparam logic [1:0] DEPTH_DIRECT = 2'd0;
   localparam logic [1:0] DEPTH_SINGLE = 2'd1;
   localparam logic [1:0] DEPTH_DOUBLE = 2'd2;

   localparam logic [CSR_WIDTH-1:0] USABLE_RESET = 9'd256;

   typedef struct packed {
      logic [LB_WIDTH-1:0] logical_block;
      logic                allocate;
   } req_type;

   typedef struct packed {
      logic [PB_WIDTH-1:0] physical_block;
      logic [1:0]          status;
      logic [1:0]          tree_depth_now;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV0,
      S_DIV1,
      S_CHECK,
      S_GROW,
      S_ROOT,
      S_READ,
      S_EVAL,
      S_CLEAR
   } state_type;

endpackage

// ===== rtl/ibmw_divider.sv =====
// Divider by a fixed divisor through reciprocal multiplication; quotient and remainder are registered.
// Depends on ibmw_pkg for the index width.
module ibmw_divider #(
   parameter int DIVISOR = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ibmw_pkg::LB_WIDTH-1:0] dividend,
   output logic                          done,
   output logic [ibmw_pkg::LB_WIDTH-1:0] quotient,
   output logic [$clog2(DIVISOR)-1:0]    remainder
);
   import ibmw_pkg::*;

   localparam int DW = $clog2(DIVISOR);
   localparam int SH = LB_WIDTH + DW;
   localparam int MW = LB_WIDTH + 2;
   localparam int PW = LB_WIDTH + MW;
   localparam logic [MW-1:0] RECIP = MW'((2 ** SH + DIVISOR - 1) / DIVISOR);

   logic [PW-1:0]       product;
   logic [LB_WIDTH-1:0] back;
   logic [LB_WIDTH-1:0] quo1_ff, quo1_in, div1_ff, div1_in;
   logic [LB_WIDTH-1:0] quo_ff, quo_in;
   logic [DW-1:0]       rem_ff, rem_in;
   logic                v1_ff, v1_in, done_ff, done_in;

   // exact for every index width value: shift is index width plus ceil(log2)
   assign product = PW'(dividend) * PW'(RECIP);
   assign back    = LB_WIDTH'(quo1_ff * LB_WIDTH'(DIVISOR));

   always_comb begin
      quo1_in = LB_WIDTH'(product >> SH);
      div1_in = dividend;
      v1_in   = start;
      quo_in  = quo1_ff;
      rem_in  = DW'(div1_ff - back);
      done_in = v1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= v1_in;
         done_ff <= done_in;
      end
      quo1_ff <= quo1_in;
      div1_ff <= div1_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/ibmw_store.sv =====
// Pointer store: single-port-write, registered-read synchronous memory.
// No dependencies.
module ibmw_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int EW    = 9
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [EW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [EW-1:0] rd_data
);

   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/inode_block_map_walker.sv =====
// Inode block map walker: translates a file block index to a physical block.
// Depends on ibmw_pkg, ibmw_divider and ibmw_store.
//
// Usage: drive req_data and raise start; the item is taken at a clock edge
// with start high and busy low. busy stays high until the result is issued.
// One result per item appears on rsp_data for a single cycle with rsp_valid
// high; the receiver cannot stall it.
// Steps: the index is split into pointer digits by two passes of the
// reciprocal divider, then a range check, the root level and, per pointer
// store level, a read and then an evaluate; each tree growth fills a new
// top pointer block, and each new pointer block is cleared when reserved.
// The result is registered. One item at a time.
// csr_write_data sets the number of usable blocks; write only while idle.
// Reset (synchronous) empties the tree: depth 0, all root pointers invalid,
// allocator at block 0, usable blocks 256. The pointer store needs no
// clearing pass; every pointer block is cleared when reserved.
module inode_block_map_walker #(
   parameter int ROOT_POINTERS      = 8,
   parameter int POINTERS_PER_BLOCK = 16,
   parameter int BLOCK_COUNT        = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  ibmw_pkg::req_type              req_data,
   output logic                           rsp_valid,
   output ibmw_pkg::rsp_type              rsp_data,
   input  logic                           csr_write_enable,
   input  logic [ibmw_pkg::CSR_WIDTH-1:0] csr_write_data
);
   import ibmw_pkg::*;

   localparam int R      = ROOT_POINTERS;
   localparam int P      = POINTERS_PER_BLOCK;
   localparam int BW     = $clog2(BLOCK_COUNT);
   localparam int EW     = BW + 1;
   localparam int NW     = BW + 1;
   localparam int RW     = $clog2(R);
   localparam int DW     = $clog2(P);
   localparam int DEPTH  = BLOCK_COUNT * P;
   localparam int AW     = $clog2(DEPTH);
   localparam int REACH1 = R * P;
   localparam int REACH2 = R * P * P;

   state_type state_ff, state_in;

   logic [LB_WIDTH-1:0]  id_ff, id_in;
   logic                 alloc_ff, alloc_in;
   logic [LB_WIDTH-1:0]  q1_ff, q1_in;
   logic [DW-1:0]        d0_ff, d0_in, d1_ff, d1_in;
   logic [RW-1:0]        d2_ff, d2_in;
   logic [1:0]           depth_ff, depth_in;
   logic [1:0]           step_ff, step_in;
   logic [NW-1:0]        nfb_ff, nfb_in;
   logic [CSR_WIDTH-1:0] usable_ff, usable_in;
   logic [EW-1:0]        root_ff [R];
   logic [EW-1:0]        root_in [R];
   logic [BW-1:0]        cur_ff, cur_in, new_ff, new_in;
   logic [DW-1:0]        cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 div_start, div_done;
   logic [LB_WIDTH-1:0]  div_operand, div_quotient;
   logic [DW-1:0]        div_remainder;

   logic                 wr_en;
   logic [AW-1:0]        addr;
   logic [EW-1:0]        wr_data, rd_data;
   logic [BW-1:0]        base_blk;
   logic [DW-1:0]        offset;

   logic                 accept, can_take, need_grow, at_leaf, fill_last;
   logic [RW-1:0]        root_idx;
   logic [DW-1:0]        digit;
   logic [EW-1:0]        ent, grow_data;
   logic [BW-1:0]        nb;

   assign accept    = start && (state_ff == S_IDLE);
   assign can_take  = (16'(nfb_ff) < 16'(usable_ff)) && (32'(nfb_ff) < BLOCK_COUNT);
   assign need_grow = ((depth_ff == DEPTH_DIRECT) && (32'(id_ff) >= R)) ||
                      ((depth_ff == DEPTH_SINGLE) && (32'(id_ff) >= REACH1));
   assign at_leaf   = step_ff == depth_ff;
   assign fill_last = cnt_ff == DW'(P - 1);
   assign nb        = nfb_ff[BW-1:0];
   assign digit     = at_leaf ? d0_ff : d1_ff;
   assign ent       = (state_ff == S_ROOT) ? root_ff[root_idx] : rd_data;
   assign grow_data = (32'(cnt_ff) < R) ? root_ff[RW'(cnt_ff)] : '0;

   always_comb begin
      case (depth_ff)
         DEPTH_DIRECT: root_idx = RW'(id_ff);
         DEPTH_SINGLE: root_idx = RW'(q1_ff);
         default:      root_idx = d2_ff;
      endcase
   end

   // shared address: one multiply by the block size
   assign base_blk = (state_ff == S_GROW) ? new_ff : cur_ff;
   assign offset   = (state_ff == S_READ || state_ff == S_EVAL) ? digit : cnt_ff;
   assign addr     = AW'(AW'(base_blk) * AW'(P)) + AW'(offset);

   assign div_start   = accept || ((state_ff == S_DIV0) && div_done);
   assign div_operand = (state_ff == S_IDLE) ? req_data.logical_block : div_quotient;

   ibmw_divider #(
      .DIVISOR (P)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_operand),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   ibmw_store #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .EW    (EW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_DIV0;
         S_DIV0:  if (div_done) state_in = S_DIV1;
         S_DIV1:  if (div_done) state_in = S_CHECK;
         S_CHECK: begin
            if (need_grow) begin
               state_in = (alloc_ff && can_take) ? S_GROW : S_IDLE;
            end else if (depth_ff == DEPTH_DOUBLE && 32'(id_ff) >= REACH2) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_ROOT;
            end
         end
         S_GROW:  if (fill_last) state_in = S_CHECK;
         S_READ:  state_in = S_EVAL;
         S_ROOT, S_EVAL: begin
            if (ent[BW]) begin
               state_in = at_leaf ? S_IDLE : S_READ;
            end else if (alloc_ff && can_take && !at_leaf) begin
               state_in = S_CLEAR;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CLEAR: if (fill_last) state_in = S_READ;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      id_in        = id_ff;
      alloc_in     = alloc_ff;
      q1_in        = q1_ff;
      d0_in        = d0_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      depth_in     = depth_ff;
      step_in      = step_ff;
      nfb_in       = nfb_ff;
      usable_in    = csr_write_enable ? csr_write_data : usable_ff;
      root_in      = root_ff;
      cur_in       = cur_ff;
      new_in       = new_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_data      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               id_in    = req_data.logical_block;
               alloc_in = req_data.allocate;
            end
         end
         S_DIV0: begin
            if (div_done) begin
               q1_in = div_quotient;
               d0_in = div_remainder;
            end
         end
         S_DIV1: begin
            if (div_done) begin
               d1_in = div_remainder;
               d2_in = RW'(div_quotient);
            end
         end
         S_CHECK: begin
            step_in = '0;
            cnt_in  = '0;
            rsp_in  = '{physical_block: '0, status: ST_MAPPED, tree_depth_now: depth_ff};
            if (need_grow) begin
               if (!alloc_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = (32'(id_ff) >= REACH2) ? ST_RANGE : ST_UNMAPPED;
               end else if (!can_take) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ST_NOSPACE;
               end else begin
                  new_in = nb;
                  nfb_in = nfb_ff + NW'(1);
               end
            end else if (depth_ff == DEPTH_DOUBLE && 32'(id_ff) >= REACH2) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = ST_RANGE;
            end
         end
         S_GROW: begin
            wr_en   = 1'b1;
            wr_data = grow_data;
            cnt_in  = cnt_ff + DW'(1);
            if (fill_last) begin
               cnt_in = '0;
               for (int i = 0; i < R; i++) begin
                  root_in[i] = '0;
               end
               root_in[0] = {1'b1, new_ff};
               depth_in   = depth_ff + 2'd1;
            end
         end
         S_ROOT, S_EVAL: begin
            rsp_in = '{physical_block: '0, status: ST_MAPPED, tree_depth_now: depth_ff};
            if (ent[BW]) begin
               if (at_leaf) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.physical_block = PB_WIDTH'(ent[BW-1:0]);
               end else begin
                  cur_in  = ent[BW-1:0];
                  step_in = step_ff + 2'd1;
               end
            end else if (!alloc_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = ST_UNMAPPED;
            end else if (!can_take) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = ST_NOSPACE;
            end else begin
               nfb_in = nfb_ff + NW'(1);
               if (state_ff == S_ROOT) begin
                  root_in[root_idx] = {1'b1, nb};
               end else begin
                  wr_en   = 1'b1;
                  wr_data = {1'b1, nb};
               end
               if (at_leaf) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.physical_block = PB_WIDTH'(nb);
               end else begin
                  cur_in = nb;
                  cnt_in = '0;
               end
            end
         end
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            cnt_in  = cnt_ff + DW'(1);
            if (fill_last) begin
               cnt_in  = '0;
               step_in = step_ff + 2'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= DEPTH_DIRECT;
         nfb_ff       <= '0;
         usable_ff    <= USABLE_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < R; i++) begin
            root_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         nfb_ff       <= nfb_in;
         usable_ff    <= usable_in;
         rsp_valid_ff <= rsp_valid_in;
         root_ff      <= root_in;
      end
      id_ff    <= id_in;
      alloc_ff <= alloc_in;
      q1_ff    <= q1_in;
      d0_ff    <= d0_in;
      d1_ff    <= d1_in;
      d2_ff    <= d2_in;
      step_ff  <= step_in;
      cur_ff   <= cur_in;
      new_ff   <= new_in;
      cnt_ff   <= cnt_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/ibmw_checker.sv =====
// Port-level checks for the inode block map walker, bound to the top level.
// Depends on ibmw_pkg and inode_block_map_walker.
module ibmw_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input ibmw_pkg::rsp_type rsp_data
);
   import ibmw_pkg::*;

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("item taken but busy not raised");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result repeated");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result issued while busy");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_MAPPED |-> rsp_data.physical_block == '0)
      else $error("failed item carries a block number");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.tree_depth_now != 2'd3)
      else $error("tree depth out of range");

endmodule

bind inode_block_map_walker ibmw_checker u_ibmw_checker (.*);
